// ===== rtl/core/interrupt_in_ring_tracker_macros.svh =====
// ----------------------------------------------------------------------------
// Interrupt-IN ring tracker assertion macros
// Concurrent assertion wrappers that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_IN_RING_TRACKER_MACROS_SVH
`define INTERRUPT_IN_RING_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during reset.
`define IIRT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interrupt_in_ring_tracker: assertion failed");
// Next-cycle implication, sampled on clk and disabled during reset.
`define IIRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interrupt_in_ring_tracker: assertion failed");
`else
`define IIRT_ASSERT_IMPL(label, ante, cons)
`define IIRT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/iirt_pkg.sv =====
// ----------------------------------------------------------------------------
// Interrupt-IN ring tracker package
// Shared constants, codes and the result record of the ring tracker.
// ----------------------------------------------------------------------------
package iirt_pkg;

    // Default transfer ring size in TRBs.
    localparam int TRANSFER_RING_TRBS_DEFAULT = 256;

    // Largest event ring the dequeue index can address.
    localparam logic [12:0] EVENT_RING_MAX = 13'd4096;

    // TRB field encodings.
    localparam int          TRB_TYPE_SHIFT      = 10;
    localparam logic [5:0]  TRB_TYPE_NORMAL     = 6'd1;
    localparam logic [5:0]  TRB_TYPE_LINK       = 6'd6;
    localparam logic [5:0]  TRB_TYPE_XFER_EVENT = 6'd32;
    localparam logic [31:0] TRB_TC_BIT          = 32'h0000_0002;
    localparam logic [31:0] TRB_IOC_BIT         = 32'h0000_0020;
    localparam logic [31:0] NORMAL_CTRL =
        (32'(TRB_TYPE_NORMAL) << TRB_TYPE_SHIFT) | TRB_IOC_BIT;
    localparam logic [31:0] LINK_CTRL =
        (32'(TRB_TYPE_LINK) << TRB_TYPE_SHIFT) | TRB_TC_BIT;

    // Completion codes that report received data.
    localparam logic [7:0] CC_SUCCESS = 8'd1;
    localparam logic [7:0] CC_SHORT   = 8'd13;

    // Busy flag of the event ring dequeue pointer.
    localparam logic [63:0] ERDP_BUSY = 64'h0000_0000_0000_0008;

    // Input commands.
    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_EVENT  = 1'b1;

    // Result kinds.
    localparam logic KIND_TRB   = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] REG_TRANSFER_RING_BASE = 3'd0;
    localparam logic [2:0] REG_BUFFER_BASE        = 3'd1;
    localparam logic [2:0] REG_MAX_PACKET         = 3'd2;
    localparam logic [2:0] REG_EVENT_RING_BASE    = 3'd3;
    localparam logic [2:0] REG_EVENT_RING_ENTRIES = 3'd4;

    // Event outcomes.
    typedef enum logic [2:0] {
        OUT_NOT_READY  = 3'd0,
        OUT_OTHER_TYPE = 3'd1,
        OUT_OTHER_TRB  = 3'd2,
        OUT_SUCCESS    = 3'd3,
        OUT_ERROR      = 3'd4
    } outcome_t;

    // One queued item result; has_link asks for a Link TRB to follow.
    typedef struct packed {
        logic        kind;
        logic [7:0]  trb_slot;
        logic [63:0] trb_addr;
        logic [10:0] trb_length;
        logic [31:0] trb_control;
        logic        has_link;
        outcome_t    event_outcome;
        logic [7:0]  completion_code;
        logic [10:0] received_bytes;
        logic [63:0] dequeue_pointer;
    } result_t;

endpackage

// ===== rtl/core/interrupt_in_ring_tracker.sv =====
// ----------------------------------------------------------------------------
// Interrupt-IN ring tracker
// Follows one interrupt-IN endpoint's transfer ring and the event ring.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries a command: submit one read,
//   or examine one event TRB (event_word0..3). Output channel (out_valid /
//   out_stall) carries results: TRB writes for the transfer ring and event
//   results; last marks the final result of each input item.
//   A submit yields one Normal TRB write, plus a Link TRB write when the
//   enqueue index would advance to the link slot. An event yields one event result.
//   Each item is evaluated in the cycle it is accepted; its first result
//   is registered in the result queue. One item is accepted per cycle
//   while the queue has room; a submit with a Link TRB takes two output
//   transfers; the output side, one result per cycle when not stalled,
//   sets the sustained rate. A two-entry result queue lets a new item in
//   while a result waits; the input stalls only when both entries are full.
//   Configuration writes (cfg_valid / cfg_ready, always ready) must be made
//   while the block is idle; the block does not enforce this. Reset empties
//   the queue, clears the ring indexes, sets both cycle bits, and loads the
//   register defaults (max_packet 8, event_ring_entries 256, bases 0).
// ----------------------------------------------------------------------------
`include "interrupt_in_ring_tracker_macros.svh"

module interrupt_in_ring_tracker #(
    parameter int TRANSFER_RING_TRBS = iirt_pkg::TRANSFER_RING_TRBS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [31:0] event_word0,
    input  logic [31:0] event_word1,
    input  logic [31:0] event_word2,
    input  logic [31:0] event_word3,
    // Output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  trb_slot,
    output logic [31:0] trb_addr_low,
    output logic [31:0] trb_addr_high,
    output logic [10:0] trb_length,
    output logic [31:0] trb_control,
    output logic        last,
    output logic [2:0]  event_outcome,
    output logic [7:0]  completion_code,
    output logic [10:0] received_bytes,
    output logic [63:0] dequeue_pointer
);

    localparam int IDX_W = $clog2(TRANSFER_RING_TRBS);
    localparam logic [IDX_W-1:0] LINK_SLOT = IDX_W'(TRANSFER_RING_TRBS - 1);

    // Configuration registers
    logic [63:0] transfer_ring_base_reg;
    logic [63:0] buffer_base_reg;
    logic [10:0] max_packet_reg;
    logic [63:0] event_ring_base_reg;
    logic [12:0] event_ring_entries_reg;

    // Ring state
    logic [IDX_W-1:0] enqueue_index_reg, enqueue_index_next;
    logic             producer_cycle_reg, producer_cycle_next;
    logic [63:0]      pending_trb_address_reg, pending_trb_address_next;
    logic [11:0]      dequeue_index_reg, dequeue_index_next;
    logic             consumer_cycle_reg, consumer_cycle_next;

    // Result queue
    iirt_pkg::result_t queue_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg, count_next;
    logic              phase_reg, phase_next;

    iirt_pkg::result_t new_result;
    iirt_pkg::result_t head;
    logic              push, out_xfer, pop;

    // Event evaluation signals
    logic [IDX_W-1:0] enq_plus;
    logic [12:0]      deq_plus;
    logic [11:0]      deq_wrapped;
    logic             deq_wrap;
    logic [63:0]      new_dp;
    logic [5:0]       evt_type;
    logic [7:0]       evt_cc;
    logic [23:0]      evt_residue;
    logic [10:0]      evt_received;

    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transfer_ring_base_reg <= '0;
            buffer_base_reg        <= '0;
            max_packet_reg         <= 11'd8;
            event_ring_base_reg    <= '0;
            event_ring_entries_reg <= 13'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                iirt_pkg::REG_TRANSFER_RING_BASE: transfer_ring_base_reg <= cfg_data;
                iirt_pkg::REG_BUFFER_BASE:        buffer_base_reg        <= cfg_data;
                iirt_pkg::REG_MAX_PACKET:         max_packet_reg         <= cfg_data[10:0];
                iirt_pkg::REG_EVENT_RING_BASE:    event_ring_base_reg    <= cfg_data;
                iirt_pkg::REG_EVENT_RING_ENTRIES: event_ring_entries_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Ring index arithmetic for both commands and event field decode.
    always_comb
    begin
        enq_plus    = enqueue_index_reg + IDX_W'(1);
        deq_plus    = {1'b0, dequeue_index_reg} + 13'd1;
        deq_wrap    = (deq_plus >= event_ring_entries_reg) ||
                      (deq_plus >= iirt_pkg::EVENT_RING_MAX);
        deq_wrapped = deq_wrap ? 12'd0 : deq_plus[11:0];
        new_dp      = (event_ring_base_reg + 64'({deq_wrapped, 4'b0000}))
                      | iirt_pkg::ERDP_BUSY;
        evt_type    = event_word3[iirt_pkg::TRB_TYPE_SHIFT +: 6];
        evt_cc      = event_word2[31:24];
        evt_residue = event_word2[23:0];
        if (evt_residue <= {13'd0, max_packet_reg})
            evt_received = max_packet_reg - evt_residue[10:0];
        else
            evt_received = 11'd0;
    end

    // Evaluate the incoming item: its first result and the next ring state.
    always_comb
    begin
        enqueue_index_next       = enqueue_index_reg;
        producer_cycle_next      = producer_cycle_reg;
        pending_trb_address_next = pending_trb_address_reg;
        dequeue_index_next       = dequeue_index_reg;
        consumer_cycle_next      = consumer_cycle_reg;
        new_result               = '0;

        if (cmd == iirt_pkg::CMD_SUBMIT)
        begin
            new_result.kind        = iirt_pkg::KIND_TRB;
            new_result.trb_slot    = 8'(enqueue_index_reg);
            new_result.trb_addr    = buffer_base_reg;
            new_result.trb_length  = max_packet_reg;
            new_result.trb_control = iirt_pkg::NORMAL_CTRL | {31'd0, producer_cycle_reg};
            new_result.has_link    = (enq_plus == LINK_SLOT);
            new_result.event_outcome = iirt_pkg::OUT_NOT_READY;
            pending_trb_address_next = transfer_ring_base_reg
                                       + 64'({enqueue_index_reg, 4'b0000});
            if (enq_plus == LINK_SLOT)
            begin
                enqueue_index_next  = '0;
                producer_cycle_next = ~producer_cycle_reg;
            end
            else
            begin
                enqueue_index_next = enq_plus;
            end
        end
        else
        begin
            new_result.kind = iirt_pkg::KIND_EVENT;
            if (event_word3[0] != consumer_cycle_reg)
            begin
                new_result.event_outcome = iirt_pkg::OUT_NOT_READY;
            end
            else
            begin
                dequeue_index_next         = deq_wrapped;
                consumer_cycle_next        = consumer_cycle_reg ^ deq_wrap;
                new_result.dequeue_pointer = new_dp;
                priority if (evt_type != iirt_pkg::TRB_TYPE_XFER_EVENT)
                begin
                    new_result.event_outcome = iirt_pkg::OUT_OTHER_TYPE;
                end
                else if ({event_word1, event_word0} != pending_trb_address_reg)
                begin
                    new_result.event_outcome = iirt_pkg::OUT_OTHER_TRB;
                end
                else if (evt_cc == iirt_pkg::CC_SUCCESS || evt_cc == iirt_pkg::CC_SHORT)
                begin
                    new_result.event_outcome   = iirt_pkg::OUT_SUCCESS;
                    new_result.completion_code = evt_cc;
                    new_result.received_bytes  = evt_received;
                end
                else
                begin
                    new_result.event_outcome   = iirt_pkg::OUT_ERROR;
                    new_result.completion_code = evt_cc;
                end
            end
        end
    end

    // Queue handshake; a head with a Link TRB is popped after its second transfer.
    assign head      = queue_reg[rd_ptr_reg];
    assign in_stall  = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && !in_stall;
    assign out_xfer  = out_valid && !out_stall;
    assign pop       = out_xfer && !(head.has_link && !phase_reg);

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
        phase_next = phase_reg;
        if (out_xfer)
            phase_next = head.has_link && !phase_reg;
    end

    // Ring state and queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enqueue_index_reg       <= '0;
            producer_cycle_reg      <= 1'b1;
            pending_trb_address_reg <= '0;
            dequeue_index_reg       <= '0;
            consumer_cycle_reg      <= 1'b1;
            wr_ptr_reg              <= 1'b0;
            rd_ptr_reg              <= 1'b0;
            count_reg               <= 2'd0;
            phase_reg               <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                enqueue_index_reg       <= enqueue_index_next;
                producer_cycle_reg      <= producer_cycle_next;
                pending_trb_address_reg <= pending_trb_address_next;
                dequeue_index_reg       <= dequeue_index_next;
                consumer_cycle_reg      <= consumer_cycle_next;
                wr_ptr_reg              <= ~wr_ptr_reg;
            end
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
            phase_reg <= phase_next;
        end
    end

    // Queue payload
    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= new_result;
    end

    // Output drive: the queued result, or the Link TRB that follows it.
    always_comb
    begin
        if (phase_reg)
        begin
            kind            = iirt_pkg::KIND_TRB;
            trb_slot        = 8'(LINK_SLOT);
            trb_addr_low    = transfer_ring_base_reg[31:0];
            trb_addr_high   = transfer_ring_base_reg[63:32];
            trb_length      = 11'd0;
            trb_control     = iirt_pkg::LINK_CTRL | {31'd0, head.trb_control[0]};
            last            = 1'b1;
            event_outcome   = iirt_pkg::OUT_NOT_READY;
            completion_code = 8'd0;
            received_bytes  = 11'd0;
            dequeue_pointer = 64'd0;
        end
        else
        begin
            kind            = head.kind;
            trb_slot        = head.trb_slot;
            trb_addr_low    = head.trb_addr[31:0];
            trb_addr_high   = head.trb_addr[63:32];
            trb_length      = head.trb_length;
            trb_control     = head.trb_control;
            last            = (head.kind == iirt_pkg::KIND_EVENT) || !head.has_link;
            event_outcome   = head.event_outcome;
            completion_code = head.completion_code;
            received_bytes  = head.received_bytes;
            dequeue_pointer = head.dequeue_pointer;
        end
    end

    // Assertions
    `IIRT_ASSERT_IMPL(a_enq_never_link, 1'b1, enqueue_index_reg != LINK_SLOT)
    `IIRT_ASSERT_IMPL(a_link_only_after_trb, phase_reg,
                      out_valid && head.kind == iirt_pkg::KIND_TRB && head.has_link)
    `IIRT_ASSERT_NEXT(a_link_pops_head, out_xfer && phase_reg, !phase_reg)
    `IIRT_ASSERT_IMPL(a_count_bound, 1'b1, count_reg != 2'd3)

endmodule
